// ===== hdl/mmdd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mmdd_pkg
// Shared types, widths, register codes and helpers of the moving mean dip
// detector.
// ----------------------------------------------------------------------------
package mmdd_pkg;

  localparam int WINDOW_MAX_DEF = 16;
  localparam int SAMPLE_W       = 12;
  localparam int FRAC_W         = 16;
  localparam int LEVEL_W        = 28;
  localparam int LEN_W          = 5;
  localparam int THR_W          = 12;
  localparam int WEIGHT_W       = 17;
  localparam int COUNT_W        = 16;
  localparam int CFG_ADDR_W     = 4;
  localparam int CFG_DATA_W     = 32;
  localparam int FIFO_DEPTH     = 2;
  localparam int FIFO_AW        = $clog2(FIFO_DEPTH);

  localparam logic [WEIGHT_W-1:0] ONE_Q16 = WEIGHT_W'(65536);

  localparam logic [LEN_W-1:0]    LEN_RST    = LEN_W'(5);
  localparam logic [THR_W-1:0]    THR_RST    = THR_W'(70);
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST = WEIGHT_W'(66);

  localparam logic [1:0] REG_WINDOW_LENGTH = 2'd0;
  localparam logic [1:0] REG_DIP_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_BLEND_WEIGHT  = 2'd2;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                seeding;
  } item_t;

  typedef struct packed {
    logic                restart;
    logic [LEN_W-1:0]    len;
    logic [THR_W-1:0]    thr;
    logic [WEIGHT_W-1:0] weight;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREV,
    ST_MIX,
    ST_SUM,
    ST_DIV,
    ST_OUT
  } back_state_t;

  // window length as used: zero acts as one, clamp to the window depth
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] wl,
                                               input int unsigned wmax);
    logic [LEN_W-1:0] res;
    res = wl;
    if (wl == '0) begin
      res = LEN_W'(1);
    end else if ((wmax < (1 << LEN_W)) && (int'(wl) > int'(wmax))) begin
      res = LEN_W'(wmax);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/moving_mean_dip_detector.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// moving_mean_dip_detector
// Moving mean of filtered photodiode samples with dip arming and drop count.
//
//   port group  direction  word
//   in_         in         sample, 12 bit
//   out_        out        warmed_up, below_mean, drop_seen, drop_total, mean
//   cfg_        in/out     window_length, dip_threshold, blend_weight
//
// each word goes through the one-port window read pass and then the
// one-bit-per-cycle mean divider
// a two word queue keeps the input open while the back end works
// a waiting result holds the back end in its last step, so the queue stops draining
// synchronous active-low reset; the window store holds no reset value
// ----------------------------------------------------------------------------
module moving_mean_dip_detector
  import mmdd_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [SAMPLE_W-1:0]   in_sample,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_warmed_up,
  output logic                       out_below_mean,
  output logic                       out_drop_seen,
  output logic      [COUNT_W-1:0]    out_drop_total,
  output logic      [LEVEL_W-1:0]    out_mean_level,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  cfg_t  cfg;
  item_t q_item;
  item_t q_head;
  logic  q_push;
  logic  q_pop;
  logic  q_full;
  logic  q_empty;

  mmdd_front #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_sample   (in_sample),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_item      (q_item),
    .cfg         (cfg)
  );

  mmdd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  mmdd_back #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .q_head         (q_head),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_warmed_up  (out_warmed_up),
    .out_below_mean (out_below_mean),
    .out_drop_seen  (out_drop_seen),
    .out_drop_total (out_drop_total),
    .out_mean_level (out_mean_level)
  );

endmodule
`default_nettype wire

// ===== hdl/mmdd_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mmdd_div
// Serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mmdd_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 5
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic      [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;

  always_comb begin
    shifted  = {rem_r, quo_r[NUM_W-1]};
    diff     = shifted - {1'b0, den_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt = num;
      rem_nxt = '0;
      den_nxt = den;
      cnt_nxt = CNT_W'(NUM_W);
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - CNT_W'(1);
      if (!diff[DEN_W]) begin
        rem_nxt = diff[DEN_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DEN_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
      end
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
`default_nettype wire

// ===== hdl/mmdd_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mmdd_fifo
// Short queue of tagged sample words between front and back.
// ----------------------------------------------------------------------------
module mmdd_fifo
  import mmdd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire item_t push_item,
  input  wire logic  pop,
  output item_t      head,
  output logic       full,
  output logic       empty
);

  item_t              mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_r, wp_nxt;
  logic [FIFO_AW-1:0] rp_r, rp_nxt;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = push ? wp_r + FIFO_AW'(1) : wp_r;
    rp_nxt  = pop ? rp_r + FIFO_AW'(1) : rp_r;
    cnt_nxt = cnt_r + (FIFO_AW + 1)'(push) - (FIFO_AW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

  assign head  = mem_r[rp_r];
  assign full  = (cnt_r == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign empty = (cnt_r == '0);

endmodule
`default_nettype wire

// ===== hdl/mmdd_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mmdd_front
// Register port and input side: tags each sample word as seeding or detect.
// ----------------------------------------------------------------------------
module mmdd_front
  import mmdd_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [SAMPLE_W-1:0]   in_sample,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready,
  input  wire logic                  q_full,
  output logic                       q_push,
  output item_t                      q_item,
  output cfg_t                       cfg
);

  logic [LEN_W-1:0]    wl_r, wl_nxt;
  logic [THR_W-1:0]    thr_r, thr_nxt;
  logic [WEIGHT_W-1:0] wt_r, wt_nxt;
  logic [LEN_W-1:0]    fill_r, fill_nxt;
  logic                restart_r, restart_nxt;
  logic [LEN_W-1:0]    len;
  logic                wr_en;
  logic [1:0]          reg_idx;
  logic                seeding;

  assign len     = eff_len(wl_r, WINDOW_MAX);
  assign wr_en   = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx = cfg_paddr[3:2];
  assign seeding = (fill_r < len);
  assign q_push  = in_valid && !q_full;

  always_comb begin
    wl_nxt      = wl_r;
    thr_nxt     = thr_r;
    wt_nxt      = wt_r;
    fill_nxt    = fill_r;
    restart_nxt = 1'b0;
    if (q_push && seeding) begin
      fill_nxt = fill_r + LEN_W'(1);
    end
    if (wr_en) begin
      unique case (reg_idx)
        REG_WINDOW_LENGTH: begin
          wl_nxt      = cfg_pwdata[LEN_W-1:0];
          fill_nxt    = '0;
          restart_nxt = 1'b1;
        end
        REG_DIP_THRESHOLD: thr_nxt = cfg_pwdata[THR_W-1:0];
        REG_BLEND_WEIGHT:  wt_nxt  = cfg_pwdata[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WINDOW_LENGTH: cfg_prdata = CFG_DATA_W'(wl_r);
      REG_DIP_THRESHOLD: cfg_prdata = CFG_DATA_W'(thr_r);
      REG_BLEND_WEIGHT:  cfg_prdata = CFG_DATA_W'(wt_r);
      default:           cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r      <= LEN_RST;
      thr_r     <= THR_RST;
      wt_r      <= WEIGHT_RST;
      fill_r    <= '0;
      restart_r <= 1'b0;
    end else begin
      wl_r      <= wl_nxt;
      thr_r     <= thr_nxt;
      wt_r      <= wt_nxt;
      fill_r    <= fill_nxt;
      restart_r <= restart_nxt;
    end
  end

  assign in_stall       = q_full;
  assign cfg_pready     = 1'b1;
  assign q_item.sample  = in_sample;
  assign q_item.seeding = seeding;
  assign cfg.restart    = restart_r;
  assign cfg.len        = len;
  assign cfg.thr        = thr_r;
  assign cfg.weight     = (wt_r > ONE_Q16) ? ONE_Q16 : wt_r;

endmodule
`default_nettype wire

// ===== hdl/mmdd_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mmdd_back
// Detection, blend, window store, window sum and mean, result register.
// ----------------------------------------------------------------------------
module mmdd_back
  import mmdd_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cfg_t               cfg,
  input  wire item_t              q_head,
  input  wire logic               q_empty,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_warmed_up,
  output logic                    out_below_mean,
  output logic                    out_drop_seen,
  output logic [COUNT_W-1:0]      out_drop_total,
  output logic [LEVEL_W-1:0]      out_mean_level
);

  localparam int AW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int SUM_W = LEVEL_W + $clog2(WINDOW_MAX);
  localparam int PA_W  = WEIGHT_W + SAMPLE_W;
  localparam int PB_W  = WEIGHT_W + LEVEL_W;
  localparam int MIX_W = PB_W + 1;
  localparam logic [AW-1:0] LAST_SLOT = AW'(WINDOW_MAX - 1);

  back_state_t state_r, state_nxt;

  logic [LEVEL_W-1:0]  win_mem [WINDOW_MAX];
  logic [LEVEL_W-1:0]  rdata_r;
  logic [AW-1:0]       rd_addr;
  logic                mem_we;

  logic [SAMPLE_W-1:0] sample_r;
  logic                seed_r;
  logic                excur_r;
  logic                below_r;
  logic [PA_W-1:0]     prod_a_r;
  logic [PB_W-1:0]     prod_b_r;
  logic [AW-1:0]       ws_r;
  logic [AW-1:0]       rp_r;
  logic [LEN_W-1:0]    k_r;
  logic                acc_en_r;
  logic [SUM_W-1:0]    acc_r;
  logic                armed_r;
  logic [COUNT_W-1:0]  drops_r;
  logic                res_drop_r;
  logic [LEVEL_W-1:0]  mean_r;

  logic                out_valid_r;
  logic                out_warm_r;
  logic                out_below_r;
  logic                out_drop_r;
  logic [COUNT_W-1:0]  out_total_r;
  logic [LEVEL_W-1:0]  out_mean_r;

  logic [LEVEL_W-1:0]  head_s;
  logic [LEVEL_W-1:0]  diff;
  logic [AW-1:0]       prev_slot;
  logic [MIX_W-1:0]    mix;
  logic [LEVEL_W-1:0]  store_val;
  logic                out_free;
  logic                issue;
  logic                sum_done;
  logic                div_start;
  logic                div_done;
  logic [SUM_W-1:0]    div_quo;
  logic                load_out;

  assign head_s    = {q_head.sample, FRAC_W'(0)};
  assign diff      = (head_s > mean_r) ? head_s - mean_r : mean_r - head_s;
  assign prev_slot = (ws_r == '0) ? LAST_SLOT : ws_r - AW'(1);
  assign mix       = MIX_W'({prod_a_r, FRAC_W'(0)}) + MIX_W'(prod_b_r)
                     + MIX_W'(32768);
  assign store_val = (seed_r || !excur_r) ? {sample_r, FRAC_W'(0)}
                                          : mix[FRAC_W +: LEVEL_W];
  assign out_free  = !out_valid_r || !out_stall;
  assign sum_done  = (k_r == cfg.len) && !acc_en_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (!q_empty) state_nxt = ST_PREV;
      ST_PREV: state_nxt = ST_MIX;
      ST_MIX:  state_nxt = ST_SUM;
      ST_SUM:  if (sum_done) state_nxt = ST_DIV;
      ST_DIV:  if (div_done) state_nxt = ST_OUT;
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    mem_we    = 1'b0;
    issue     = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    rd_addr   = rp_r;
    unique case (state_r)
      ST_IDLE: begin
        q_pop   = !q_empty;
        rd_addr = prev_slot;
      end
      ST_PREV: ;
      ST_MIX:  mem_we = 1'b1;
      ST_SUM: begin
        issue     = (k_r != cfg.len);
        div_start = sum_done;
      end
      ST_DIV: ;
      ST_OUT:  load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      win_mem[ws_r] <= store_val;
    end
    rdata_r <= win_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ws_r        <= '0;
      k_r         <= '0;
      acc_en_r    <= 1'b0;
      armed_r     <= 1'b0;
      drops_r     <= '0;
      mean_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      acc_en_r <= issue;
      if (cfg.restart) begin
        armed_r <= 1'b0;
      end
      if (mem_we) begin
        ws_r <= (ws_r == LAST_SLOT) ? '0 : ws_r + AW'(1);
        k_r  <= '0;
        if (!seed_r) begin
          if (excur_r) begin
            if (below_r) armed_r <= 1'b1;
          end else begin
            if (armed_r) drops_r <= drops_r + COUNT_W'(1);
            armed_r <= 1'b0;
          end
        end
      end
      if (issue) begin
        k_r <= k_r + LEN_W'(1);
      end
      if (load_out) begin
        mean_r      <= div_quo[LEVEL_W-1:0];
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end

    if (q_pop) begin
      sample_r <= q_head.sample;
      seed_r   <= q_head.seeding;
      excur_r  <= diff > {cfg.thr, FRAC_W'(0)};
      below_r  <= head_s < mean_r;
    end
    if (state_r == ST_PREV) begin
      prod_a_r <= PA_W'(cfg.weight) * PA_W'(sample_r);
      prod_b_r <= PB_W'(ONE_Q16 - cfg.weight) * PB_W'(rdata_r);
    end
    if (mem_we) begin
      rp_r       <= ws_r;
      acc_r      <= '0;
      res_drop_r <= !seed_r && !excur_r && armed_r;
    end
    if (issue) begin
      rp_r <= (rp_r == '0) ? LAST_SLOT : rp_r - AW'(1);
    end
    if (acc_en_r) begin
      acc_r <= acc_r + SUM_W'(rdata_r);
    end
    if (load_out) begin
      out_warm_r  <= !seed_r;
      out_below_r <= !seed_r && excur_r && below_r;
      out_drop_r  <= res_drop_r;
      out_total_r <= drops_r;
      out_mean_r  <= div_quo[LEVEL_W-1:0];
    end
  end

  mmdd_div #(
    .NUM_W (SUM_W),
    .DEN_W (LEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (acc_r),
    .den   (cfg.len),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign out_valid      = out_valid_r;
  assign out_warmed_up  = out_warm_r;
  assign out_below_mean = out_below_r;
  assign out_drop_seen  = out_drop_r;
  assign out_drop_total = out_total_r;
  assign out_mean_level = out_mean_r;

endmodule
`default_nettype wire
